@@ rtl/jsp_pkg.sv @@
// Shared types and constants for the joystick port with analog sequencer.
package jsp_pkg;

	// Command codes of one request
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_LOAD  = 2'd2
	} cmd_t;

	// Pad type codes; codes above PAD_NONE behave as no pad
	typedef enum logic [2:0] {
		PAD_TWO_BUTTON = 3'd0,
		PAD_DIGITAL    = 3'd1,
		PAD_SIX_MD     = 3'd2,
		PAD_SIX_SFC    = 3'd3,
		PAD_ANALOG     = 3'd4,
		PAD_NONE       = 3'd5
	} pad_type_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PORT0_TYPE = 2'd0,
		REG_PORT1_TYPE = 2'd1,
		REG_READS_STEP = 2'd2
	} reg_idx_t;

	localparam logic [3:0] SEQ_WORDS      = 4'd13;
	localparam logic [3:0] READS_RESET    = 4'd3;
	localparam logic [7:0] BYTE_ALL_HIGH  = 8'hff;
	localparam logic [7:0] WORD_LOW_TAG   = 8'h90;
	localparam logic [7:0] WORD_HIGH_TAG  = 8'hb0;
	localparam logic [7:0] WORD_BTN_TAG   = 8'h93;
	localparam logic [7:0] WORD_BTN_MASK  = 8'h0c;
	localparam logic [7:0] WORD_END       = 8'hbf;
	localparam logic [7:0] AXIS_X_RESET   = 8'h97;
	localparam logic [7:0] AXIS_Y_RESET   = 8'hb7;
	localparam logic [7:0] AXIS_T_RESET   = 8'h97;

	// One request as held in the input stage
	typedef struct packed {
		logic [1:0] cmd;
		logic       port;
		logic [7:0] write_data;
		logic [7:0] button_byte0;
		logic [7:0] button_byte1;
		logic [7:0] axis_x;
		logic [7:0] axis_y;
		logic [7:0] axis_throttle;
	} jsp_item_t;

	// Control from the port logic to the analog sequencer
	typedef struct packed {
		logic rd;
		logic restart;
	} seq_ctl_t;

endpackage

@@ rtl/jsp_seq.sv @@
// Analog-stick readout sequencer: step counter, read counter and word select.
module jsp_seq import jsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  seq_ctl_t   ctl,
	input  logic [3:0] reads_per_step,
	input  logic [7:0] btn0,
	input  logic [7:0] btn1,
	input  logic [7:0] ax_x,
	input  logic [7:0] ax_y,
	input  logic [7:0] ax_t,
	output logic [7:0] word
);

	logic [3:0] step_q;
	logic [3:0] reads_left_q;
	logic [3:0] reads_dec;
	logic [7:0] base_word;
	logic       at_end;

	always_comb begin
		case (step_q)
			4'd1:    base_word = btn0;
			4'd2:    base_word = btn1;
			4'd3:    base_word = WORD_LOW_TAG  | {4'd0, ax_y[7:4]};
			4'd4:    base_word = WORD_HIGH_TAG | {4'd0, ax_x[7:4]};
			4'd5:    base_word = WORD_LOW_TAG  | {4'd0, ax_t[7:4]};
			4'd6:    base_word = WORD_HIGH_TAG;
			4'd7:    base_word = WORD_LOW_TAG  | {4'd0, ax_y[3:0]};
			4'd8:    base_word = WORD_HIGH_TAG | {4'd0, ax_x[3:0]};
			4'd9:    base_word = WORD_LOW_TAG  | {4'd0, ax_t[3:0]};
			4'd10:   base_word = WORD_HIGH_TAG;
			4'd11:   base_word = WORD_BTN_TAG | (btn0 & WORD_BTN_MASK);
			4'd12:   base_word = WORD_END;
			default: base_word = BYTE_ALL_HIGH;
		endcase
	end

	// saturate at zero
	assign reads_dec = (reads_left_q != 4'd0) ? reads_left_q - 4'd1 : 4'd0;
	assign at_end    = step_q >= SEQ_WORDS;
	assign word      = (reads_dec == 4'd0 && at_end) ? BYTE_ALL_HIGH : base_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= 4'd0;
			reads_left_q <= READS_RESET;
		end else if (ctl.restart) begin
			step_q       <= 4'd0;
			reads_left_q <= reads_per_step;
		end else if (ctl.rd) begin
			if (reads_dec == 4'd0 && !at_end) begin
				step_q       <= step_q + 4'd1;
				reads_left_q <= reads_per_step;
			end else begin
				reads_left_q <= reads_dec;
			end
		end
	end

endmodule

@@ rtl/jsp_core.sv @@
// Port state (latches, button bytes, analog values) and read data path.
module jsp_core import jsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  jsp_item_t  item,
	input  logic [2:0] port0_pad_type,
	input  logic [2:0] port1_pad_type,
	input  logic [3:0] reads_per_step,
	output logic [7:0] read_data
);

	logic [7:0] latch_q   [2];
	logic [7:0] buttons_q [4];
	logic [7:0] axis_x_q, axis_y_q, axis_t_q;
	logic [2:0] ty;
	logic       high;
	logic [7:0] seq_word;
	logic [1:0] idx0, idx1;
	seq_ctl_t   ctl;

	assign ty   = item.port ? port1_pad_type : port0_pad_type;
	assign high = latch_q[item.port] == BYTE_ALL_HIGH;
	assign idx0 = {item.port, 1'b0};
	assign idx1 = {item.port, 1'b1};

	assign ctl.rd      = go && item.cmd == CMD_READ && ty == PAD_ANALOG && !item.port;
	assign ctl.restart = go && item.cmd == CMD_WRITE && ty == PAD_ANALOG && !item.port
		&& item.write_data == 8'd0 && latch_q[0] == BYTE_ALL_HIGH;

	jsp_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.reads_per_step (reads_per_step),
		.btn0           (buttons_q[0]),
		.btn1           (buttons_q[1]),
		.ax_x           (axis_x_q),
		.ax_y           (axis_y_q),
		.ax_t           (axis_t_q),
		.word           (seq_word)
	);

	always_comb begin
		case (ty)
			PAD_ANALOG:
				read_data = item.port ? BYTE_ALL_HIGH : seq_word;
			PAD_DIGITAL, PAD_SIX_MD, PAD_SIX_SFC:
				read_data = high ? buttons_q[idx1] : buttons_q[idx0];
			PAD_TWO_BUTTON:
				read_data = high ? BYTE_ALL_HIGH : buttons_q[idx0];
			default:
				read_data = BYTE_ALL_HIGH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q[0]   <= 8'd0;
			latch_q[1]   <= 8'd0;
			buttons_q[0] <= BYTE_ALL_HIGH;
			buttons_q[1] <= BYTE_ALL_HIGH;
			buttons_q[2] <= BYTE_ALL_HIGH;
			buttons_q[3] <= BYTE_ALL_HIGH;
			axis_x_q     <= AXIS_X_RESET;
			axis_y_q     <= AXIS_Y_RESET;
			axis_t_q     <= AXIS_T_RESET;
		end else if (go) begin
			if (item.cmd == CMD_WRITE && ty <= PAD_ANALOG) begin
				latch_q[item.port] <= item.write_data;
			end
			if (item.cmd == CMD_LOAD) begin
				buttons_q[idx0] <= item.button_byte0;
				buttons_q[idx1] <= item.button_byte1;
				if (ty == PAD_ANALOG) begin
					axis_x_q <= item.axis_x;
					axis_y_q <= item.axis_y;
					axis_t_q <= item.axis_throttle;
				end
			end
		end
	end

endmodule

@@ rtl/joystick_port_with_analog_sequencer.sv @@
// Top level: request input stage, configuration registers and read result register.
// A read request passes through the input stage and then the result register, which
// offers its result until it is taken.
// Throughput: one request per cycle; a read holds in the input stage while an untaken
// result waits, stalling the requests behind it; write or load requests never hold there.
// A write or load request gives no result and retires in the cycle after acceptance.
// Reset (arst_n low, asynchronous): pad types 0, reads_per_step 3, latches 0,
// button bytes 0xff, analog values 0x97/0xb7/0x97, sequencer at step 0.
module joystick_port_with_analog_sequencer import jsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic       port,
	input  logic [7:0] write_data,
	input  logic [7:0] button_byte0,
	input  logic [7:0] button_byte1,
	input  logic [7:0] axis_x,
	input  logic [7:0] axis_y,
	input  logic [7:0] axis_throttle,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	// configuration write port
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	jsp_item_t  item_s1;
	logic       valid_s1;
	logic       is_read_s1;
	logic       go_s1;
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic [7:0] core_data;
	logic [2:0] port0_type_q;
	logic [2:0] port1_type_q;
	logic [3:0] reads_step_q;

	// A read may leave the input stage only when the result register is free
	// or being emptied in this cycle; other requests leave at once.
	assign is_read_s1 = item_s1.cmd == CMD_READ;
	assign go_s1      = valid_s1 && (!is_read_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || go_s1;

	// Input stage: hold the request until it is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd, port: port, write_data: write_data,
				button_byte0: button_byte0, button_byte1: button_byte1,
				axis_x: axis_x, axis_y: axis_y, axis_throttle: axis_throttle};
		end
	end

	// Configuration registers; the user must write them only while the block is idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port0_type_q <= PAD_TWO_BUTTON;
			port1_type_q <= PAD_TWO_BUTTON;
			reads_step_q <= READS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PORT0_TYPE: port0_type_q <= cfg_data[2:0];
				REG_PORT1_TYPE: port1_type_q <= cfg_data[2:0];
				REG_READS_STEP: reads_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Port state and read path; state advances as the request leaves stage one.
	jsp_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (go_s1),
		.item           (item_s1),
		.port0_pad_type (port0_type_q),
		.port1_pad_type (port1_type_q),
		.reads_per_step (reads_step_q),
		.read_data      (core_data)
	);

	// Result register: load on a read leaving stage one, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && is_read_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_read_s1) begin
			read_data_q <= core_data;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule
